// ===== src/mm4c_pkg.sv =====
// Shared types and constants for the 4x4 column matrix multiply engine.
package mm4c_pkg;

   // Element format and derived widths.
   localparam int ELEM_WIDTH = 32;
   localparam int ROWS       = 4;
   localparam int COL_WIDTH  = $clog2(ROWS);
   localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;

   // Operation codes carried by an input beat.
   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_MULTIPLY = 1'b1;

   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef logic [SUM_WIDTH-1:0]  sum_type;

   // Saturation bounds of a signed element.
   localparam elem_type ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

   // Input beat: one column of A (load) or of B (multiply).
   typedef struct packed {
      logic                         op;
      logic [COL_WIDTH-1:0]         col_index;
      logic signed [ELEM_WIDTH-1:0] value_0;
      logic signed [ELEM_WIDTH-1:0] value_1;
      logic signed [ELEM_WIDTH-1:0] value_2;
      logic signed [ELEM_WIDTH-1:0] value_3;
   } req_type;

   // Result beat: one column of A*B.
   typedef struct packed {
      logic [COL_WIDTH-1:0]         out_col_index;
      logic signed [ELEM_WIDTH-1:0] prod_0;
      logic signed [ELEM_WIDTH-1:0] prod_1;
      logic signed [ELEM_WIDTH-1:0] prod_2;
      logic signed [ELEM_WIDTH-1:0] prod_3;
      logic                         saturated;
   } rsp_type;

   // Beat travelling down the cell chain with its running row sums.
   typedef struct packed {
      logic                      op;
      logic [COL_WIDTH-1:0]      col;
      elem_type [ROWS-1:0]       vals;
      sum_type [ROWS-1:0]        sums;
   } beat_type;

endpackage

// ===== src/mm4c_cell.sv =====
// One chain cell: holds one column of A and adds its four products to the row sums.
module mm4c_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mm4c_pkg::beat_type  in_beat,
   output logic                out_valid,
   input  logic                out_ready,
   output mm4c_pkg::beat_type  out_beat
);
   import mm4c_pkg::*;

   elem_type [ROWS-1:0]                  a_col_ff;
   elem_type [ROWS-1:0]                  a_col_in;
   logic                                 mul_valid_ff;
   beat_type                             mul_beat_ff;
   logic [ROWS-1:0][PROD_WIDTH-1:0]      prod_ff;
   logic [ROWS-1:0][PROD_WIDTH-1:0]      prod_in;
   logic                                 add_valid_ff;
   beat_type                             add_beat_ff;
   beat_type                             add_beat_in;
   logic                                 mul_en;
   logic                                 add_en;

   // Each stage moves when it is empty or its successor moves.
   assign add_en   = !add_valid_ff || out_ready;
   assign mul_en   = !mul_valid_ff || add_en;
   assign in_ready = mul_en;

   // A load beat for this column overwrites the stored column as it passes.
   always_comb begin
      a_col_in = a_col_ff;
      if (in_valid && mul_en && (in_beat.op == OP_LOAD) &&
          (in_beat.col == COL_WIDTH'(CELL_INDEX))) begin
         a_col_in = in_beat.vals;
      end
   end

   // Multiply stage: each stored row element times this cell's element of B.
   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         prod_in[r] = $signed(a_col_ff[r]) * $signed(in_beat.vals[CELL_INDEX]);
      end
   end

   // Add stage: fold the registered products into the running sums.
   always_comb begin
      add_beat_in = mul_beat_ff;
      for (int r = 0; r < ROWS; r++) begin
         add_beat_in.sums[r] = mul_beat_ff.sums[r] +
                               {{(SUM_WIDTH-PROD_WIDTH){prod_ff[r][PROD_WIDTH-1]}}, prod_ff[r]};
      end
   end

   // Control and stored column.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_col_ff     <= '0;
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
      end else begin
         a_col_ff <= a_col_in;
         if (mul_en) begin
            mul_valid_ff <= in_valid;
         end
         if (add_en) begin
            add_valid_ff <= mul_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (mul_en && in_valid) begin
         mul_beat_ff <= in_beat;
         prod_ff     <= prod_in;
      end
      if (add_en && mul_valid_ff) begin
         add_beat_ff <= add_beat_in;
      end
   end

   assign out_valid = add_valid_ff;
   assign out_beat  = add_beat_ff;

endmodule

// ===== src/mm4c_finish.sv =====
// Output stage: rounds, shifts and saturates the row sums into the result register.
module mm4c_finish #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mm4c_pkg::beat_type  in_beat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mm4c_pkg::rsp_type   rsp_data
);
   import mm4c_pkg::*;

   // Half of one output LSB, added before the shift; zero when there are no fraction bits.
   localparam sum_type HALF    = sum_type'((SUM_WIDTH'(1) << FRAC_BITS) >> 1);
   localparam sum_type MAX_SUM = {{(SUM_WIDTH-ELEM_WIDTH){1'b0}}, ELEM_MAX};
   localparam sum_type MIN_SUM = {{(SUM_WIDTH-ELEM_WIDTH){1'b1}}, ELEM_MIN};

   sum_type [ROWS-1:0]  rounded;
   sum_type [ROWS-1:0]  shifted;
   elem_type [ROWS-1:0] result;
   logic [ROWS-1:0]     clip;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   logic                take;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready && (in_beat.op == OP_MULTIPLY);

   // Round to nearest, arithmetic shift, clamp to the element range.
   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         rounded[r] = in_beat.sums[r] + HALF;
         shifted[r] = $signed(rounded[r]) >>> FRAC_BITS;
         if ($signed(shifted[r]) > $signed(MAX_SUM)) begin
            result[r] = ELEM_MAX;
            clip[r]   = 1'b1;
         end else if ($signed(shifted[r]) < $signed(MIN_SUM)) begin
            result[r] = ELEM_MIN;
            clip[r]   = 1'b1;
         end else begin
            result[r] = shifted[r][ELEM_WIDTH-1:0];
            clip[r]   = 1'b0;
         end
      end
   end

   // Assemble the result beat.
   always_comb begin
      rsp_data_in.out_col_index = in_beat.col;
      rsp_data_in.prod_0        = result[0];
      rsp_data_in.prod_1        = result[1];
      rsp_data_in.prod_2        = result[2];
      rsp_data_in.prod_3        = result[3];
      rsp_data_in.saturated     = |clip;
   end

   // Load beats end here; only multiply beats fill the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid && (in_beat.op == OP_MULTIPLY);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/matrix_multiply_4x4_column.sv =====
// Top level of the streaming 4x4 column matrix multiply engine.
//
// Input channel (req_valid / req_ready / req_data): each beat carries one
// column. A load beat (op 0) replaces column col_index of the stored left
// matrix A and gives no result. A multiply beat (op 1) carries column
// col_index of B and gives that column of A*B on the result channel.
// Result channel (rsp_valid / rsp_ready / rsp_data): four signed Q16.16
// elements, rounded to nearest and saturated, with a flag if any clipped.
// The data path is a chain of four cells, cell k holding column k of A;
// each beat passes a multiply register and then an add register in every
// cell and the result register of the output stage. One beat is accepted
// per cycle while the result side keeps up.
// Loads travel the chain in order with multiplies, so every multiply sees
// exactly the loads accepted before it.
// Reset clears A to zero and empties the chain. When the receiver stalls,
// the result register holds and the chain keeps accepting beats until
// every stage is full; then req_ready drops.
module matrix_multiply_4x4_column #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mm4c_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mm4c_pkg::rsp_type rsp_data
);
   import mm4c_pkg::*;

   logic     chain_valid [ROWS+1];
   logic     chain_ready [ROWS+1];
   beat_type chain_beat  [ROWS+1];

   // Entry of the chain: the input beat with zero running sums.
   always_comb begin
      chain_beat[0].op      = req_data.op;
      chain_beat[0].col     = req_data.col_index;
      chain_beat[0].vals[0] = req_data.value_0;
      chain_beat[0].vals[1] = req_data.value_1;
      chain_beat[0].vals[2] = req_data.value_2;
      chain_beat[0].vals[3] = req_data.value_3;
      chain_beat[0].sums    = '0;
   end

   assign chain_valid[0] = req_valid;
   assign req_ready      = chain_ready[0];

   // One cell per column of A.
   for (genvar k = 0; k < ROWS; k++) begin : g_cell
      mm4c_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_beat   (chain_beat[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_beat  (chain_beat[k+1])
      );
   end

   mm4c_finish #(
      .FRAC_BITS (FRAC_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[ROWS]),
      .in_ready  (chain_ready[ROWS]),
      .in_beat   (chain_beat[ROWS]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // No result is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // With the result register empty, every stage can move, so input is taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused while the result side is empty");

   // A load leaving the chain never turns into a result.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      chain_valid[ROWS] && chain_ready[ROWS] && (chain_beat[ROWS].op == OP_LOAD)
      |=> !rsp_valid)
      else $error("load beat produced a result");

   // A clipped column holds at least one element at a range bound.
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
      (rsp_data.prod_0 == ELEM_MAX) || (rsp_data.prod_0 == ELEM_MIN) ||
      (rsp_data.prod_1 == ELEM_MAX) || (rsp_data.prod_1 == ELEM_MIN) ||
      (rsp_data.prod_2 == ELEM_MAX) || (rsp_data.prod_2 == ELEM_MIN) ||
      (rsp_data.prod_3 == ELEM_MAX) || (rsp_data.prod_3 == ELEM_MIN))
      else $error("saturated flag without a clipped element");

endmodule

// ===== dv/matrix_multiply_4x4_column_checker.sv =====
// Checker that predicts and compares the result beats of the 4x4 column matrix multiply engine.
module matrix_multiply_4x4_column_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mm4c_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mm4c_pkg::rsp_type rsp_data,
   output int                pending_columns,
   output int                mismatch_count
);
   import mm4c_pkg::*;

   // Wide enough for four full 64-bit products plus rounding.
   localparam int ACC_WIDTH = 2 * ELEM_WIDTH + 4;
   typedef logic signed [ACC_WIDTH-1:0] acc_type;

   localparam acc_type SAT_HIGH = (acc_type'(1) <<< (ELEM_WIDTH - 1)) - acc_type'(1);
   localparam acc_type SAT_LOW  = -(acc_type'(1) <<< (ELEM_WIDTH - 1));

   // Our own copy of the stored left matrix, element index col*4+row.
   logic signed [ELEM_WIDTH-1:0] left_elems [ROWS*ROWS];
   rsp_type                      expected_columns [$];
   int                           errors = 0;

   // Computes the product column A*b for one multiply beat.
   function automatic rsp_type product_column(input req_type beat);
      rsp_type  column;
      elem_type right [ROWS];
      elem_type elem_out;
      acc_type  acc;
      acc_type  a_term;
      acc_type  b_term;
      logic     clip;
      right[0] = beat.value_0;
      right[1] = beat.value_1;
      right[2] = beat.value_2;
      right[3] = beat.value_3;
      clip = 1'b0;
      column = '0;
      column.out_col_index = beat.col_index;
      for (int row = 0; row < ROWS; row++) begin
         acc = '0;
         for (int k = 0; k < ROWS; k++) begin
            a_term = left_elems[k*ROWS + row];
            b_term = signed'(right[k]);
            acc += a_term * b_term;
         end
         // Round to nearest with ties upward, then drop the fraction bits.
         if (FRAC_BITS > 0)
            acc += acc_type'(1) <<< (FRAC_BITS - 1);
         acc = acc >>> FRAC_BITS;
         if (acc > SAT_HIGH) begin
            elem_out = ELEM_MAX;
            clip = 1'b1;
         end else if (acc < SAT_LOW) begin
            elem_out = ELEM_MIN;
            clip = 1'b1;
         end else begin
            elem_out = acc[ELEM_WIDTH-1:0];
         end
         case (row)
            0: column.prod_0 = elem_out;
            1: column.prod_1 = elem_out;
            2: column.prod_2 = elem_out;
            default: column.prod_3 = elem_out;
         endcase
      end
      column.saturated = clip;
      return column;
   endfunction

   // Track loads, queue expected columns, and compare each result beat.
   always @(posedge clock) begin
      rsp_type expected;
      if (reset) begin
         for (int i = 0; i < ROWS*ROWS; i++)
            left_elems[i] = '0;
         expected_columns.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.op == OP_LOAD) begin
               left_elems[int'(req_data.col_index)*ROWS + 0] = req_data.value_0;
               left_elems[int'(req_data.col_index)*ROWS + 1] = req_data.value_1;
               left_elems[int'(req_data.col_index)*ROWS + 2] = req_data.value_2;
               left_elems[int'(req_data.col_index)*ROWS + 3] = req_data.value_3;
            end else begin
               expected_columns.push_back(product_column(req_data));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_columns.size() == 0) begin
               $error("result beat with no column expected: col %0d", rsp_data.out_col_index);
               errors++;
            end else begin
               expected = expected_columns.pop_front();
               if (rsp_data.out_col_index !== expected.out_col_index) begin
                  $error("out_col_index mismatch: expected %0d, got %0d",
                         expected.out_col_index, rsp_data.out_col_index);
                  errors++;
               end
               if (rsp_data.prod_0 !== expected.prod_0) begin
                  $error("prod_0 mismatch: expected %0d, got %0d",
                         expected.prod_0, rsp_data.prod_0);
                  errors++;
               end
               if (rsp_data.prod_1 !== expected.prod_1) begin
                  $error("prod_1 mismatch: expected %0d, got %0d",
                         expected.prod_1, rsp_data.prod_1);
                  errors++;
               end
               if (rsp_data.prod_2 !== expected.prod_2) begin
                  $error("prod_2 mismatch: expected %0d, got %0d",
                         expected.prod_2, rsp_data.prod_2);
                  errors++;
               end
               if (rsp_data.prod_3 !== expected.prod_3) begin
                  $error("prod_3 mismatch: expected %0d, got %0d",
                         expected.prod_3, rsp_data.prod_3);
                  errors++;
               end
               if (rsp_data.saturated !== expected.saturated) begin
                  $error("saturated mismatch: expected %0d, got %0d",
                         expected.saturated, rsp_data.saturated);
                  errors++;
               end
            end
         end
      end
      pending_columns <= expected_columns.size();
      mismatch_count  <= errors;
   end

endmodule

// ===== dv/matrix_multiply_4x4_column_tb.sv =====
// Testbench top that drives beats into the 4x4 column matrix multiply engine and gives the verdict.
module matrix_multiply_4x4_column_tb;
   import mm4c_pkg::*;

   localparam int       FRAC_BITS    = 16;
   localparam int       ITEM_TARGET  = 1600;
   localparam int       CYCLE_LIMIT  = 200000;
   localparam int       LONG_HOLD    = 400;
   localparam int       DRAIN_CYCLES = 20;
   localparam elem_type ONE_Q        = 32'h0001_0000;
   localparam elem_type HALF_LSB     = 32'h0000_8000;
   localparam elem_type NEG_HALF_LSB = 32'hFFFF_8000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      pending_columns;
   int      mismatch_count;
   int      beats_sent = 0;
   int      columns_taken = 0;
   int      cycle_count = 0;

   matrix_multiply_4x4_column #(
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   matrix_multiply_4x4_column_checker #(
      .FRAC_BITS (FRAC_BITS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .pending_columns (pending_columns),
      .mismatch_count  (mismatch_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hang anywhere in the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type column_beat(input logic op, input logic [COL_WIDTH-1:0] col,
                                           input elem_type v0, v1, v2, v3);
      req_type beat;
      beat.op        = op;
      beat.col_index = col;
      beat.value_0   = v0;
      beat.value_1   = v1;
      beat.value_2   = v2;
      beat.value_3   = v3;
      return beat;
   endfunction

   // Mostly moderate Q16.16 values, with extremes and full-range noise mixed in.
   function automatic elem_type random_element();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return elem_type'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
         4:          return elem_type'($urandom_range(0, 32'h0000_0400)) - 32'h0000_0200;
         5:          return ELEM_MAX;
         6:          return ELEM_MIN;
         default:    return elem_type'($urandom());
      endcase
   endfunction

   function automatic req_type random_beat(input logic op, input logic [COL_WIDTH-1:0] col);
      return column_beat(op, col, random_element(), random_element(),
                         random_element(), random_element());
   endfunction

   // Offers one beat after a random gap (none in every fourth run of 64 beats) and holds it until it is accepted.
   task automatic send_beat(input req_type beat);
      int gap;
      gap = ((beats_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // Writes the same value into every element of the left matrix.
   task automatic load_uniform(input elem_type value);
      for (int c = 0; c < ROWS; c++)
         send_beat(column_beat(OP_LOAD, COL_WIDTH'(c), value, value, value, value));
   endtask

   // Waits until every expected column has come back.
   task automatic wait_for_results();
      do @(posedge clock); while (pending_columns != 0);
   endtask

   // Result side: random stalls per beat, bursts without stalls, and two long hold-offs.
   initial begin : result_sink
      int gap;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (columns_taken == 40 || columns_taken == 300) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = ((columns_taken / 50) % 4 == 3) ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         columns_taken++;
      end
   end

   // Request side: directed beats, then random traffic, then the verdict.
   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A multiply before any load sees an all-zero left matrix.
      send_beat(column_beat(OP_MULTIPLY, 2'd3, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN));

      // An identity left matrix passes extreme columns through unchanged.
      for (int c = 0; c < ROWS; c++)
         send_beat(column_beat(OP_LOAD, COL_WIDTH'(c),
                               (c == 0) ? ONE_Q : '0, (c == 1) ? ONE_Q : '0,
                               (c == 2) ? ONE_Q : '0, (c == 3) ? ONE_Q : '0));
      send_beat(column_beat(OP_MULTIPLY, 2'd0, ELEM_MAX, ELEM_MIN, '1, '0));
      send_beat(column_beat(OP_MULTIPLY, 2'd1, '0, '1, ELEM_MIN, ELEM_MAX));

      // Largest magnitudes clip high and low.
      load_uniform(ELEM_MAX);
      send_beat(column_beat(OP_MULTIPLY, 2'd2, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
      send_beat(column_beat(OP_MULTIPLY, 2'd3, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));

      // Four products of the most negative elements sum beyond 64 bits and clip high.
      load_uniform(ELEM_MIN);
      send_beat(column_beat(OP_MULTIPLY, 2'd1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));

      // Rounding: exact ties go upward, just below or above a tie goes to nearest.
      load_uniform(elem_type'(1));
      send_beat(column_beat(OP_MULTIPLY, 2'd0, HALF_LSB, '0, '0, '0));
      send_beat(column_beat(OP_MULTIPLY, 2'd2, NEG_HALF_LSB, '0, '0, '0));
      send_beat(column_beat(OP_MULTIPLY, 2'd3, HALF_LSB - 1, '0, '0, '0));
      send_beat(column_beat(OP_MULTIPLY, 2'd1, NEG_HALF_LSB - 1, '0, '0, '0));

      req_valid <= 1'b0;
      wait_for_results();

      // Random part: mostly a fresh left matrix followed by a run of multiplies.
      while (beats_sent < ITEM_TARGET) begin
         if (!paused && beats_sent >= ITEM_TARGET / 2) begin
            req_valid <= 1'b0;
            wait_for_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) < 7) begin
            for (int c = 0; c < ROWS; c++)
               send_beat(random_beat(OP_LOAD, COL_WIDTH'(c)));
            repeat ($urandom_range(1, 8))
               send_beat(random_beat(OP_MULTIPLY, COL_WIDTH'($urandom_range(0, 3))));
         end else begin
            send_beat(random_beat(1'($urandom_range(0, 1)), COL_WIDTH'($urandom_range(0, 3))));
         end
      end

      // Let everything drain and wait for stray beats, then give the verdict.
      req_valid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/mm4c_pkg.sv
src/mm4c_cell.sv
src/mm4c_finish.sv
src/matrix_multiply_4x4_column.sv
dv/matrix_multiply_4x4_column_checker.sv
dv/matrix_multiply_4x4_column_tb.sv
